// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_AT(lbl, clk, rstn, !(cond), msg)

`endif

// File: sv/amt_pkg.sv
// ---------------------------------------------------------------------------
// amt_pkg
// Types and constants shared by the adaptive mean threshold modules.
// ---------------------------------------------------------------------------
`default_nettype none

package amt_pkg;

  // Transaction opcodes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_WINDOW_RADIUS  = 2'd2;
  localparam logic [1:0] REG_OFFSET_EPSILON = 2'd3;

  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CW         = 7;   // frame size / coordinate width
  localparam int unsigned POS_W      = 6;   // port coordinate width
  localparam int unsigned RAD_W      = 4;
  localparam int unsigned EPS_W      = 9;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 18;  // 31 x 31 x 255 fits
  localparam int unsigned CNT_W      = 10;  // up to 961 window pixels
  localparam int unsigned CMP_W      = SUM_W + 2;
  localparam int unsigned STEP_W     = $clog2(SUM_W);

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

  typedef struct packed {
    logic [CW-1:0]           frame_width;
    logic [CW-1:0]           frame_height;
    logic [RAD_W-1:0]        window_radius;
    logic signed [EPS_W-1:0] offset_epsilon;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch and clamp query coordinates
    logic bounds;     // latch window bounds, clear accumulators
    logic rd_center;  // read centre pixel
    logic rd_scan;    // read window pixel, advance scan position
    logic div_load;   // load divider
    logic div_step;   // one restoring division step
    logic finish;     // register result and strobe
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // scan position is bottom right of window
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: sv/amt_ram.sv
// ---------------------------------------------------------------------------
// amt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module amt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/amt_ctrl.sv
// ---------------------------------------------------------------------------
// amt_ctrl
// Query sequencer: window scan, division and result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module amt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               is_query_i,
  input  wire amt_pkg::ctrl_sts_t sts_i,
  output amt_pkg::ctrl_cmd_t      cmd_o,
  output logic                    busy_o
);

  import amt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOUND,
    S_SCAN,
    S_DRAIN,
    S_DIVLD,
    S_DIV,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && is_query_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BOUND;
        end
      end
      S_BOUND: begin
        cmd_o.bounds    = 1'b1;
        cmd_o.rd_center = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last read land in the accumulator
        state_d = S_DIVLD;
      end
      S_DIVLD: begin
        cmd_o.div_load = 1'b1;
        step_d         = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(SUM_W - 1)) begin
          state_d = S_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: sv/amt_datapath.sv
// ---------------------------------------------------------------------------
// amt_datapath
// Frame store, window scan, accumulator, serial divider and comparator.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module amt_datapath #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire amt_pkg::cfg_t                 cfg_i,
  input  wire amt_pkg::ctrl_cmd_t            cmd_i,
  output amt_pkg::ctrl_sts_t                 sts_o,
  input  wire logic [amt_pkg::POS_W-1:0]     q_row_i,
  input  wire logic [amt_pkg::POS_W-1:0]     q_col_i,
  input  wire logic                          wr_en_i,
  input  wire logic [amt_pkg::POS_W-1:0]     wr_row_i,
  input  wire logic [amt_pkg::POS_W-1:0]     wr_col_i,
  input  wire logic [amt_pkg::PIX_W-1:0]     wr_data_i,
  output logic      [amt_pkg::POS_W-1:0]     out_row_o,
  output logic      [amt_pkg::POS_W-1:0]     out_col_o,
  output logic      [amt_pkg::PIX_W-1:0]     binary_o,
  output logic                               done_o
);

  import amt_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Effective frame size and radius
  logic [CW-1:0]    w_eff, h_eff, wm1, hm1;
  logic [RAD_W-1:0] r_eff;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      w_eff = CW'(1);
    end else if (int'(cfg_i.frame_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      h_eff = CW'(1);
    end else if (int'(cfg_i.frame_height) > MAX_HEIGHT) begin
      h_eff = CW'(MAX_HEIGHT);
    end else begin
      h_eff = cfg_i.frame_height;
    end
    if (int'(cfg_i.window_radius) > MAX_RADIUS) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = cfg_i.window_radius;
    end
  end

  assign wm1 = w_eff - 1'b1;
  assign hm1 = h_eff - 1'b1;

  // Query coordinates, clamped into the frame
  logic [CW-1:0] row_q, col_q, row_ext, col_ext;

  assign row_ext = {1'b0, q_row_i};
  assign col_ext = {1'b0, q_col_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q <= (row_ext > hm1) ? hm1 : row_ext;
      col_q <= (col_ext > wm1) ? wm1 : col_ext;
    end
  end

  // Window bounds
  logic [CW-1:0] r_ext, top, bot, left, right, row_plus, col_plus;

  assign r_ext    = CW'(r_eff);
  assign row_plus = row_q + r_ext;
  assign col_plus = col_q + r_ext;
  assign top      = (row_q >= r_ext) ? row_q - r_ext : '0;
  assign left     = (col_q >= r_ext) ? col_q - r_ext : '0;
  assign bot      = (row_plus > hm1) ? hm1 : row_plus;
  assign right    = (col_plus > wm1) ? wm1 : col_plus;

  logic [CW-1:0] bot_q, left_q, right_q, y_q, x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.bounds) begin
      bot_q   <= bot;
      left_q  <= left;
      right_q <= right;
      y_q     <= top;
      x_q     <= left;
    end else if (cmd_i.rd_scan) begin
      if (x_q == right_q) begin
        x_q <= left_q;
        y_q <= y_q + 1'b1;
      end else begin
        x_q <= x_q + 1'b1;
      end
    end
  end

  assign sts_o.scan_last = (x_q == right_q) && (y_q == bot_q);

  // Frame store
  logic          wr_ok;
  logic [AW-1:0] waddr, raddr, center_addr, scan_addr;
  logic [PIX_W-1:0] rdata;

  assign wr_ok       = wr_en_i && (int'(wr_row_i) < MAX_HEIGHT) && (int'(wr_col_i) < MAX_WIDTH);
  assign waddr       = AW'(wr_row_i) * AW'(MAX_WIDTH) + AW'(wr_col_i);
  assign center_addr = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign scan_addr   = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);
  assign raddr       = cmd_i.rd_center ? center_addr : scan_addr;

  amt_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (waddr),
    .wdata_i (wr_data_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read tags follow the registered RAM read
  logic ctr_pend_q, win_pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_pend_q <= 1'b0;
      win_pend_q <= 1'b0;
    end else begin
      ctr_pend_q <= cmd_i.rd_center;
      win_pend_q <= cmd_i.rd_scan;
    end
  end

  // Accumulator
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] count_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.bounds) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (win_pend_q) begin
      sum_q   <= sum_q + SUM_W'(rdata);
      count_q <= count_q + 1'b1;
    end
    if (ctr_pend_q) begin
      pix_q <= rdata;
    end
  end

  // Restoring divider, one quotient bit per step
  logic [CNT_W:0]   rem_q, trial;
  logic [SUM_W-1:0] quo_q;
  logic             fits;

  assign trial = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, count_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= '0;
      quo_q <= sum_q;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? (trial - {1'b0, count_q}) : trial;
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

  // Threshold compare and result register
  logic signed [CMP_W-1:0] mean_s, eps_s, pix_s, diff_s;

  assign mean_s = $signed({2'b00, quo_q});
  assign eps_s  = CMP_W'($signed(cfg_i.offset_epsilon));
  assign pix_s  = $signed({{(CMP_W-PIX_W){1'b0}}, pix_q});
  assign diff_s = mean_s - eps_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_row_o <= row_q[POS_W-1:0];
      out_col_o <= col_q[POS_W-1:0];
      binary_o  <= (diff_s > pix_s) ? PIX_BLACK : PIX_WHITE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.finish;
    end
  end

  `ASSERT_AT(a_div_count_nonzero, clk_i, rst_ni, cmd_i.div_load |-> (count_q != '0),
             "division started on an empty window")

endmodule

`default_nettype wire

// File: sv/adaptive_mean_threshold.sv
// ---------------------------------------------------------------------------
// adaptive_mean_threshold
// Local-mean binarisation of an 8-bit gray frame held in an on-chip store.
// ---------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A write
// (cmd_i = 0) stores gray_value_i at pixel_row_i / pixel_col_i and leaves
// busy low, so writes stream at one per cycle while no query holds busy
// high. A query (cmd_i = 1) clamps its coordinates into the configured
// frame, reads the centre pixel and then the clipped square window one
// pixel per cycle through the single read port of the frame store, sums
// it, divides by the pixel count (at most 961 for radius 15) in an
// 18-step restoring divider and compares. The result (out_row_o,
// out_col_o, binary_value_o = 0 black / 255 white) is shown for exactly
// one cycle with done_o high; the receiver cannot stall, so capture it
// in that cycle. busy is already low while done_o is high, so the next
// transaction may be taken then.
// There is no clearing pass: every pixel of a window must be written before
// it is queried. Write the configuration registers only while idle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adaptive_mean_threshold #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64,
  parameter int unsigned MAX_RADIUS = 15
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // command channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cmd_i,
  input  wire logic [amt_pkg::POS_W-1:0]        pixel_row_i,
  input  wire logic [amt_pkg::POS_W-1:0]        pixel_col_i,
  input  wire logic [amt_pkg::PIX_W-1:0]        gray_value_i,
  // result channel
  output logic                                  done_o,
  output logic      [amt_pkg::POS_W-1:0]        out_row_o,
  output logic      [amt_pkg::POS_W-1:0]        out_col_o,
  output logic      [amt_pkg::PIX_W-1:0]        binary_value_o,
  // configuration write port
  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_addr_i,
  input  wire logic [amt_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import amt_pkg::*;

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= CW'(64);
      cfg_q.frame_height   <= CW'(64);
      cfg_q.window_radius  <= RAD_W'(1);
      cfg_q.offset_epsilon <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_wdata_i[CW-1:0];
        REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_wdata_i[CW-1:0];
        REG_WINDOW_RADIUS:  cfg_q.window_radius  <= cfg_wdata_i[RAD_W-1:0];
        REG_OFFSET_EPSILON: cfg_q.offset_epsilon <= $signed(cfg_wdata_i[EPS_W-1:0]);
        default: begin
          // hold: no such register
        end
      endcase
    end
  end

  // Transaction decode
  logic      take;
  logic      take_write;
  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  assign take       = start && !busy;
  assign take_write = take && (cmd_i == CMD_WRITE);

  amt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .is_query_i (cmd_i == CMD_QUERY),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd),
    .busy_o     (busy)
  );

  amt_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .cmd_i     (ctrl_cmd),
    .sts_o     (ctrl_sts),
    .q_row_i   (pixel_row_i),
    .q_col_i   (pixel_col_i),
    .wr_en_i   (take_write),
    .wr_row_i  (pixel_row_i),
    .wr_col_i  (pixel_col_i),
    .wr_data_i (gray_value_i),
    .out_row_o (out_row_o),
    .out_col_o (out_col_o),
    .binary_o  (binary_value_o),
    .done_o    (done_o)
  );

  // One strobe per query, never back to back
  `ASSERT_AT(a_done_single, clk_i, rst_ni, done_o |=> !done_o,
             "result strobe held for more than one cycle")
  // A write never occupies the block
  `ASSERT_AT(a_write_no_busy, clk_i, rst_ni, take_write |=> !busy,
             "write transaction left the block busy")
  // A query always occupies the block
  `ASSERT_AT(a_query_busy, clk_i, rst_ni, (take && (cmd_i == CMD_QUERY)) |=> busy,
             "query transaction not started")
  // The strobe cycle is already idle
  `ASSERT_NEVER(a_done_idle, clk_i, rst_ni, done_o && busy,
                "result strobe while still busy")

endmodule

`default_nettype wire

// File: verif/adaptive_mean_threshold_test.sv
// ---------------------------------------------------------------------------
// adaptive_mean_threshold_test
// Self-checking testbench for the adaptive mean threshold block. A square
// corner of the frame store is loaded first, then directed and random
// write/query transactions run under a series of frame, radius and epsilon
// settings, every query window kept on written pixels. Every query verdict
// is predicted from a local copy of the frame and the settings, and compared
// field by field against the result strobe.
// ---------------------------------------------------------------------------
module adaptive_mean_threshold_test;
  timeunit 1ns;
  timeprecision 1ps;

  import amt_pkg::*;

  localparam int unsigned FRAME_MAX     = 64;
  localparam int unsigned RADIUS_MAX    = 15;
  localparam int unsigned LOAD_SIZE     = 20;    // loaded square at the top left
  localparam int unsigned CLK_PERIOD    = 8;
  localparam int unsigned RESET_CYCLES  = 3;
  localparam int unsigned STALL_LIMIT   = 5000;  // well above the worst query
  localparam int unsigned SETTLE_CYCLES = 1000;  // one full-window query and then some
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RANDOM_PHASES = 12;

  // Sender idle percentage per phase: none, heavy, none (receiver cannot
  // stall, so that phase runs clean), light.
  localparam int unsigned IDLE_MIX [4] = '{0, 56, 0, 19};

  typedef struct {
    logic             cmd;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] gray;
  } pixel_op_t;

  typedef struct {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] level;
  } verdict_t;

  // Clock, reset and every block input start at a known value.
  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic                  cmd_i        = CMD_WRITE;
  logic [POS_W-1:0]      pixel_row_i  = '0;
  logic [POS_W-1:0]      pixel_col_i  = '0;
  logic [PIX_W-1:0]      gray_value_i = '0;
  logic                  cfg_we_i     = 1'b0;
  logic [1:0]            cfg_addr_i   = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;

  logic             busy;
  logic             done_o;
  logic [POS_W-1:0] out_row_o;
  logic [POS_W-1:0] out_col_o;
  logic [PIX_W-1:0] binary_value_o;

  // Predictor state: the frame as written and the register settings.
  logic [PIX_W-1:0]        frame_image [FRAME_MAX*FRAME_MAX];
  logic [CW-1:0]           width_setting;
  logic [CW-1:0]           height_setting;
  logic [RAD_W-1:0]        radius_setting;
  logic signed [EPS_W-1:0] epsilon_setting;

  pixel_op_t   ops_to_send [$];
  verdict_t    verdicts_due [$];
  int unsigned idle_pct     = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  logic        op_taken     = 1'b0;

  adaptive_mean_threshold dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .gray_value_i   (gray_value_i),
    .done_o         (done_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .binary_value_o (binary_value_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // Clamp the query into the frame, average the clipped window (truncating)
  // and compare the mean less epsilon against the centre pixel.
  function automatic verdict_t threshold_of(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
    int unsigned w, h, r, top, bottom, first_col, last_col, y, x, sum, count;
    int          mean, centre;
    verdict_t    v;
    // A zero size reads as one; anything past the store saturates.
    w = (width_setting == 0) ? 1 : (width_setting > FRAME_MAX ? FRAME_MAX : width_setting);
    h = (height_setting == 0) ? 1 : (height_setting > FRAME_MAX ? FRAME_MAX : height_setting);
    r = (radius_setting > RADIUS_MAX) ? RADIUS_MAX : radius_setting;
    v.row = (row > h - 1) ? POS_W'(h - 1) : row;
    v.col = (col > w - 1) ? POS_W'(w - 1) : col;
    top       = (v.row >= r) ? v.row - r : 0;
    bottom    = (v.row + r > h - 1) ? h - 1 : v.row + r;
    first_col = (v.col >= r) ? v.col - r : 0;
    last_col  = (v.col + r > w - 1) ? w - 1 : v.col + r;
    sum   = 0;
    count = 0;
    for (y = top; y <= bottom; y++) begin
      for (x = first_col; x <= last_col; x++) begin
        sum += frame_image[y*FRAME_MAX + x];
        count++;
      end
    end
    mean   = sum / count;
    centre = frame_image[v.row*FRAME_MAX + v.col];
    v.level = (mean - int'(epsilon_setting) > centre) ? PIX_BLACK : PIX_WHITE;
    return v;
  endfunction

  // Keep a query window on the loaded square: a frame no larger than the
  // square is covered whatever the coordinate, a larger one needs the
  // coordinate pulled in so that the window stops inside the square.
  function automatic int unsigned safe_coord(int unsigned raw, int unsigned size,
                                             int unsigned r);
    return (size <= LOAD_SIZE) ? raw : raw % (LOAD_SIZE - r);
  endfunction

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Driver: present the next pending transaction at the falling edge; hold
  // it until the block takes it, idle at random in between.
  always @(negedge clk_i) begin
    pixel_op_t op;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || op_taken) begin
      if (ops_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        op = ops_to_send.pop_front();
        start        <= 1'b1;
        cmd_i        <= op.cmd;
        pixel_row_i  <= op.row;
        pixel_col_i  <= op.col;
        gray_value_i <= op.gray;
      end else begin
        // Scramble the payload while idle; the block must ignore it.
        start        <= 1'b0;
        cmd_i        <= 1'($urandom_range(1));
        pixel_row_i  <= POS_W'($urandom_range(63));
        pixel_col_i  <= POS_W'($urandom_range(63));
        gray_value_i <= PIX_W'($urandom_range(255));
      end
    end
  end

  // Monitor: track register writes, check results against the oldest
  // outstanding verdict, then apply the transaction taken at this edge.
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      width_setting   = CW'(FRAME_MAX);
      height_setting  = CW'(FRAME_MAX);
      radius_setting  = RAD_W'(1);
      epsilon_setting = '0;
      op_taken       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_FRAME_WIDTH:    width_setting   = cfg_wdata_i[CW-1:0];
          REG_FRAME_HEIGHT:   height_setting  = cfg_wdata_i[CW-1:0];
          REG_WINDOW_RADIUS:  radius_setting  = cfg_wdata_i[RAD_W-1:0];
          REG_OFFSET_EPSILON: epsilon_setting = cfg_wdata_i[EPS_W-1:0];
          default: ;
        endcase
      end
      if (done_o) begin
        if (verdicts_due.size() == 0) begin
          note_mismatch($sformatf("result row %0d col %0d value %0d with no query outstanding",
                                  out_row_o, out_col_o, binary_value_o));
        end else begin
          want = verdicts_due.pop_front();
          if (out_row_o !== want.row || out_col_o !== want.col ||
              binary_value_o !== want.level)
            note_mismatch($sformatf("expected row %0d col %0d value %0d, got row %0d col %0d value %0d",
                                    want.row, want.col, want.level,
                                    out_row_o, out_col_o, binary_value_o));
        end
      end
      // A verdict is fixed when the query is taken: no write can land while busy.
      if (start && !busy) begin
        if (cmd_i == CMD_WRITE)
          frame_image[{pixel_row_i, pixel_col_i}] = gray_value_i;
        else
          verdicts_due.push_back(threshold_of(pixel_row_i, pixel_col_i));
      end
      op_taken <= start && !busy;
    end
  end

  // Watchdog: give up if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_op(logic cmd, int unsigned row, int unsigned col, int unsigned gray);
    pixel_op_t op;
    op.cmd  = cmd;
    op.row  = POS_W'(row);
    op.col  = POS_W'(col);
    op.gray = PIX_W'(gray);
    ops_to_send.push_back(op);
  endtask

  // Wait until every transaction is taken and every verdict has arrived,
  // then let a trailing write land.
  task automatic drain;
    do @(posedge clk_i); while (ops_to_send.size() != 0 || start);
    do @(negedge clk_i); while (verdicts_due.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic program_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                               logic [CFG_DATA_W-1:0] r, logic [CFG_DATA_W-1:0] eps);
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    write_register(REG_WINDOW_RADIUS, r);
    write_register(REG_OFFSET_EPSILON, eps);
  endtask

  // Stimulus: load the store, run the directed checks, then random phases.
  initial begin
    logic [CFG_DATA_W-1:0] w_data, h_data, r_data, e_data;
    int unsigned           w_eff, h_eff, r_eff, n_ops;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Load the top-left square before any query; every window stays on it
    // or on the corner patches written below.
    for (int unsigned a = 0; a < LOAD_SIZE*LOAD_SIZE; a++)
      queue_op(CMD_WRITE, a / LOAD_SIZE, a % LOAD_SIZE, $urandom_range(255));

    // Reset settings: extreme gray levels at the corners, query corners and
    // an inner pixel. Fill the 2 by 2 patch at each far corner.
    queue_op(CMD_WRITE, 0, 0, 8'h00);
    queue_op(CMD_WRITE, 0, 63, 8'hFF);
    queue_op(CMD_WRITE, 63, 0, 8'hFF);
    queue_op(CMD_WRITE, 63, 63, 8'h00);
    queue_op(CMD_WRITE, 0, 62, $urandom_range(255));
    queue_op(CMD_WRITE, 1, 62, $urandom_range(255));
    queue_op(CMD_WRITE, 1, 63, $urandom_range(255));
    queue_op(CMD_WRITE, 62, 0, $urandom_range(255));
    queue_op(CMD_WRITE, 62, 1, $urandom_range(255));
    queue_op(CMD_WRITE, 63, 1, $urandom_range(255));
    queue_op(CMD_WRITE, 62, 62, $urandom_range(255));
    queue_op(CMD_WRITE, 62, 63, $urandom_range(255));
    queue_op(CMD_WRITE, 63, 62, $urandom_range(255));
    queue_op(CMD_QUERY, 0, 0, 8'hFF);
    queue_op(CMD_QUERY, 0, 63, 0);
    queue_op(CMD_QUERY, 63, 0, 0);
    queue_op(CMD_QUERY, 63, 63, 0);
    queue_op(CMD_QUERY, 10, 10, 0);
    drain();

    // Zero radius, zero epsilon: mean equals pixel, so the tie goes white.
    program_frame(9'd64, 9'd64, 9'd0, 9'd0);
    idle_pct = IDLE_MIX[1];
    queue_op(CMD_QUERY, 12, 14, 0);
    queue_op(CMD_WRITE, 12, 14, 8'hFF);
    queue_op(CMD_QUERY, 12, 14, 0);
    drain();

    // Zero-sized frame reads as one pixel; epsilon of minus one tips it black.
    // A write outside the configured frame is still stored.
    program_frame(9'd0, 9'd0, 9'd15, 9'h1FF);
    queue_op(CMD_QUERY, 63, 63, 0);
    queue_op(CMD_WRITE, 5, 5, 8'h80);
    drain();

    // Oversized frame saturates to the store edge; most negative epsilon.
    program_frame(9'd127, 9'd100, 9'd1, 9'h100);
    queue_op(CMD_QUERY, 63, 63, 0);
    queue_op(CMD_QUERY, 0, 63, 0);
    queue_op(CMD_QUERY, 5, 5, 0);
    drain();

    // Largest positive epsilon forces white, full radius.
    program_frame(9'd64, 9'd64, 9'd15, 9'd255);
    queue_op(CMD_QUERY, 4, 4, 0);
    drain();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 6)
        0:       w_data = 9'd1;
        1:       w_data = 9'd64;
        2:       w_data = 9'd0;
        3:       w_data = CFG_DATA_W'($urandom_range(65, 511));
        default: w_data = CFG_DATA_W'($urandom_range(1, 64));
      endcase
      case ((p + 3) % 6)
        0:       h_data = 9'd1;
        1:       h_data = 9'd64;
        2:       h_data = 9'd0;
        3:       h_data = CFG_DATA_W'($urandom_range(65, 511));
        default: h_data = CFG_DATA_W'($urandom_range(1, 64));
      endcase
      // Keep most windows small; only a few phases pay for the full radius.
      if (p == 4 || p == 9)
        r_data = CFG_DATA_W'(RADIUS_MAX);
      else if ($urandom_range(3) == 0)
        r_data = CFG_DATA_W'($urandom_range(4, 14));
      else
        r_data = CFG_DATA_W'($urandom_range(3));
      r_data[CFG_DATA_W-1:RAD_W] = (CFG_DATA_W-RAD_W)'($urandom_range(31));
      case (p % 5)
        0:       e_data = 9'h100;
        1:       e_data = 9'h101;
        2:       e_data = 9'd255;
        3:       e_data = CFG_DATA_W'($urandom_range(511));
        default: e_data = CFG_DATA_W'($urandom_range(32) - 16);
      endcase
      program_frame(w_data, h_data, r_data, e_data);

      w_eff = (w_data[CW-1:0] == 0) ? 1 : (w_data[CW-1:0] > FRAME_MAX ? FRAME_MAX : w_data[CW-1:0]);
      h_eff = (h_data[CW-1:0] == 0) ? 1 : (h_data[CW-1:0] > FRAME_MAX ? FRAME_MAX : h_data[CW-1:0]);
      r_eff = r_data[RAD_W-1:0];
      n_ops = (r_eff > 7) ? 12 : 16;
      idle_pct = IDLE_MIX[p % 4];
      for (int unsigned k = 0; k < n_ops; k++) begin
        if ($urandom_range(1) == 0)
          queue_op(CMD_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(255));
        else if ($urandom_range(1) == 0)
          queue_op(CMD_QUERY, safe_coord($urandom_range(h_eff - 1), h_eff, r_eff),
                   safe_coord($urandom_range(w_eff - 1), w_eff, r_eff),
                   $urandom_range(255));
        else
          queue_op(CMD_QUERY, safe_coord($urandom_range(63), h_eff, r_eff),
                   safe_coord($urandom_range(63), w_eff, r_eff), $urandom_range(255));
      end
      drain();
    end

    // Hold a while longer to catch any stray result.
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && verdicts_due.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/amt_pkg.sv
sv/amt_ram.sv
sv/amt_ctrl.sv
sv/amt_datapath.sv
sv/adaptive_mean_threshold.sv
verif/adaptive_mean_threshold_test.sv
